// ===== src/tfp_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 step for the frame parser.
package tfp_pkg;

	localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [5:0]  FRAME_LEN   = 6'd53;
	localparam logic [5:0]  PAYLOAD_LEN = 6'd49;
	localparam logic [5:0]  COUNT_MAX   = 6'd63;
	localparam logic [5:0]  SEQ_START   = 6'd4;
	localparam logic [5:0]  TIME_START  = 6'd8;
	localparam logic [5:0]  MEAS_START  = 6'd16;
	localparam logic [5:0]  SUN_POS     = 6'd48;
	localparam int          NUM_MEAS    = 4;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_LEN = 2'd1,
		ST_CRC = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] satellite_id;
		logic [31:0] sequence_number;
		logic [63:0] timestamp;
		logic [63:0] battery_bits;
		logic [63:0] temperature_bits;
		logic [63:0] altitude_bits;
		logic [63:0] velocity_bits;
		logic        in_sunlight;
		logic [31:0] received_crc;
	} result_t;

	// Reflected CRC-32 over one byte, LSB first.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/tfp_gather.sv =====
// Byte counter, CRC accumulator and field capture; forms the frame result.
module tfp_gather import tfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output result_t       res
);

	logic [5:0]  count_q;
	logic [31:0] crc_q;
	logic [31:0] id_q;
	logic [31:0] seq_q;
	logic [63:0] time_q;
	logic [63:0] meas_q [NUM_MEAS];
	logic        sun_q;
	logic [31:0] rx_crc_q;

	logic [5:0]  meas_off;
	logic [1:0]  meas_idx;
	logic [31:0] rx_crc_n;

	assign meas_off = count_q - MEAS_START;
	assign meas_idx = meas_off[4:3];
	// received CRC including this byte, used when the frame ends here
	assign rx_crc_n = {rx_crc_q[23:0], data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			crc_q    <= CRC_INIT;
			id_q     <= '0;
			seq_q    <= '0;
			time_q   <= '0;
			sun_q    <= 1'b0;
			rx_crc_q <= '0;
			for (int i = 0; i < NUM_MEAS; i++) begin
				meas_q[i] <= '0;
			end
		end else if (accept) begin
			if (last_byte) begin
				count_q  <= '0;
				crc_q    <= CRC_INIT;
				id_q     <= '0;
				seq_q    <= '0;
				time_q   <= '0;
				sun_q    <= 1'b0;
				rx_crc_q <= '0;
				for (int i = 0; i < NUM_MEAS; i++) begin
					meas_q[i] <= '0;
				end
			end else begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 6'd1;
				end
				if (count_q < PAYLOAD_LEN) begin
					crc_q <= crc_byte(crc_q, data_byte);
				end
				if (count_q < SEQ_START) begin
					id_q <= {id_q[23:0], data_byte};
				end else if (count_q < TIME_START) begin
					seq_q <= {seq_q[23:0], data_byte};
				end else if (count_q < MEAS_START) begin
					time_q <= {time_q[55:0], data_byte};
				end else if (count_q < SUN_POS) begin
					meas_q[meas_idx] <= {meas_q[meas_idx][55:0], data_byte};
				end else if (count_q == SUN_POS) begin
					sun_q <= (data_byte != 8'd0);
				end else if (count_q < FRAME_LEN) begin
					rx_crc_q <= rx_crc_n;
				end
			end
		end
	end

	// A correct frame ends on byte 52; the CRC covers only bytes 0..48,
	// so crc_q is final by then.
	always_comb begin
		res = '0;
		if (count_q != FRAME_LEN - 6'd1) begin
			res.status = ST_LEN;
		end else begin
			res.status           = ((crc_q ^ CRC_INIT) == rx_crc_n) ? ST_OK : ST_CRC;
			res.satellite_id     = id_q;
			res.sequence_number  = seq_q;
			res.timestamp        = time_q;
			res.battery_bits     = meas_q[0];
			res.temperature_bits = meas_q[1];
			res.altitude_bits    = meas_q[2];
			res.velocity_bits    = meas_q[3];
			res.in_sunlight      = sun_q;
			res.received_crc     = rx_crc_n;
		end
	end

endmodule

// ===== src/tfp_out_reg.sv =====
// Result register with valid/ready handshake.
module tfp_out_reg import tfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_ready,
	output logic    out_valid,
	output logic    free,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== src/telemetry_frame_parser_crc32.sv =====
// Top level of the fixed 53-byte telemetry frame parser with CRC-32 check.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | sink      | in_valid / in_ready  | data_byte, last_byte
//  out     | source    | out_valid / out_ready| status and the nine frame fields
//
// One byte per cycle while in_ready is high: the byte-wide CRC step and the field
// shift feed the capture registers, the CRC compare sits between them and the
// result register, and out_valid rises in the cycle after the last byte. in_ready drops
// only while a result is held and out_ready is low. Reset (arst_n low) clears the
// byte count, the CRC to all ones, every gathered field and the result valid flag.
module telemetry_frame_parser_crc32 import tfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] satellite_id,
	output logic [31:0] sequence_number,
	output logic [63:0] timestamp,
	output logic [63:0] battery_bits,
	output logic [63:0] temperature_bits,
	output logic [63:0] altitude_bits,
	output logic [63:0] velocity_bits,
	output logic        in_sunlight,
	output logic [31:0] received_crc
);

	logic    in_acc;
	logic    out_free;
	result_t frame_res;
	result_t res_q;

	// bytes stall whenever a held result is not being taken this cycle
	assign in_ready = out_free;
	assign in_acc   = in_valid && in_ready;

	tfp_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res       (frame_res)
	);

	// a result is produced only by the final word of a frame
	tfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_acc && last_byte),
		.res_in    (frame_res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (out_free),
		.res_out   (res_q)
	);

	assign status           = res_q.status;
	assign satellite_id     = res_q.satellite_id;
	assign sequence_number  = res_q.sequence_number;
	assign timestamp        = res_q.timestamp;
	assign battery_bits     = res_q.battery_bits;
	assign temperature_bits = res_q.temperature_bits;
	assign altitude_bits    = res_q.altitude_bits;
	assign velocity_bits    = res_q.velocity_bits;
	assign in_sunlight      = res_q.in_sunlight;
	assign received_crc     = res_q.received_crc;

	// final word always yields a result on the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_byte |=> out_valid)
		else $error("final word did not produce a result");

	// a non-final word never raises a fresh result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !last_byte && (!out_valid || out_ready) |=> !out_valid)
		else $error("result appeared without a final word");

	// status code 3 is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_LEN || status == ST_CRC))
		else $error("illegal status code");

	// wrong length clears every field
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_LEN |-> satellite_id == 32'd0 &&
		received_crc == 32'd0 && !in_sunlight && timestamp == 64'd0)
		else $error("length error result carries field data");

endmodule
